@@ design/vgr_pkg.sv @@
package vgr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SQUARE_W  = 31;
  localparam int ENERGY_W  = 39;
  localparam int MEAN_W    = 31;
  localparam int THRESH_W  = 16;
  localparam int HANG_W    = 16;
  localparam int FRAME_W   = 9;
  localparam int FLUSH_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DIV_BITS  = ENERGY_W;
  localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_VOX_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HANG_FRAMES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SAMPLES = 2'd2;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd500;
  localparam logic [HANG_W-1:0]   HANG_RESET   = 16'd10;
  localparam logic [FRAME_W-1:0]  FRAME_RESET  = 9'd160;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
  localparam logic [MEAN_W-1:0]   MEAN_MAX   = {MEAN_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_MEAN_START,
    ST_MEAN_DIV,
    ST_MEAN_SAT,
    ST_NEWTON_START,
    ST_NEWTON_DIV,
    ST_NEWTON_UPD,
    ST_DECIDE
  } vgr_state_e;

  typedef struct packed {
    logic load;
    logic square;
    logic accum;
    logic div_start_mean;
    logic div_start_newton;
    logic div_step;
    logic mean_load;
    logic newton_upd;
    logic decide;
  } vgr_cmd_t;

  typedef struct packed {
    logic last;
    logic skip_rms;
    logic div_last;
    logic mean_zero;
    logic steps_last;
    logic out_free;
  } vgr_sts_t;

endpackage

@@ design/vgr_if.sv @@
interface vgr_in_if;
  import vgr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_in_frame;
  logic                       ptt;

  modport source (output valid, output sample, output last_in_frame, output ptt,
                  input ready);
  modport sink (input valid, input sample, input last_in_frame, input ptt,
                output ready);
endinterface

interface vgr_out_if;
  import vgr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 transmit_frame;
  logic [FLUSH_W-1:0]   flush_count;
  logic                 voice_active;
  logic [MEAN_W-1:0]    frame_rms;

  modport source (output valid, output transmit_frame, output flush_count,
                  output voice_active, output frame_rms, input ready);
  modport sink (input valid, input transmit_frame, input flush_count,
                input voice_active, input frame_rms, output ready);
endinterface

@@ design/vgr_ctrl.sv @@
module vgr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vgr_pkg::vgr_sts_t sts_i,
  output vgr_pkg::vgr_cmd_t cmd_o
);
  import vgr_pkg::*;

  vgr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SQUARE;
      end
      ST_SQUARE: state_d = ST_ACCUM;
      ST_ACCUM: begin
        if (!sts_i.last) state_d = ST_IDLE;
        else if (sts_i.skip_rms) state_d = ST_DECIDE;
        else state_d = ST_MEAN_START;
      end
      ST_MEAN_START: state_d = ST_MEAN_DIV;
      ST_MEAN_DIV: begin
        if (sts_i.div_last) state_d = ST_MEAN_SAT;
      end
      ST_MEAN_SAT: begin
        if (sts_i.mean_zero) state_d = ST_DECIDE;
        else state_d = ST_NEWTON_START;
      end
      ST_NEWTON_START: state_d = ST_NEWTON_DIV;
      ST_NEWTON_DIV: begin
        if (sts_i.div_last) state_d = ST_NEWTON_UPD;
      end
      ST_NEWTON_UPD: begin
        if (sts_i.steps_last) state_d = ST_DECIDE;
        else state_d = ST_NEWTON_START;
      end
      ST_DECIDE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SQUARE:       cmd_o.square = 1'b1;
      ST_ACCUM:        cmd_o.accum = 1'b1;
      ST_MEAN_START:   cmd_o.div_start_mean = 1'b1;
      ST_MEAN_DIV:     cmd_o.div_step = 1'b1;
      ST_MEAN_SAT:     cmd_o.mean_load = 1'b1;
      ST_NEWTON_START: cmd_o.div_start_newton = 1'b1;
      ST_NEWTON_DIV:   cmd_o.div_step = 1'b1;
      ST_NEWTON_UPD:   cmd_o.newton_upd = 1'b1;
      ST_DECIDE:       cmd_o.decide = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ design/vgr_datapath.sv @@
module vgr_datapath #(
  parameter int LOOKBACK_DEPTH = 3,
  parameter int SQRT_STEPS     = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vgr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [vgr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic signed [vgr_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  input  logic                                ptt_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                transmit_frame_o,
  output logic [vgr_pkg::FLUSH_W-1:0]         flush_count_o,
  output logic                                voice_active_o,
  output logic [vgr_pkg::MEAN_W-1:0]          frame_rms_o,
  input  vgr_pkg::vgr_cmd_t                   cmd_i,
  output vgr_pkg::vgr_sts_t                   sts_o
);
  import vgr_pkg::*;

  localparam int LB_W   = $clog2(LOOKBACK_DEPTH + 1);
  localparam int LBX_W  = (LB_W > FLUSH_W) ? LB_W : FLUSH_W;
  localparam int STEP_W = $clog2(SQRT_STEPS + 1);

  logic [THRESH_W-1:0] thr_q;
  logic [HANG_W-1:0]   hang_frames_q;
  logic [FRAME_W-1:0]  frame_q;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q, ptt_q;
  logic [SQUARE_W-1:0]        sq_q;
  logic [ENERGY_W-1:0]        energy_q, energy_d;
  logic [HANG_W-1:0]          hang_q, hang_d;
  logic                       voice_q, voice_d;
  logic                       was_q, was_d;
  logic [LB_W-1:0]            look_q, look_d;
  logic                       prev_ptt_q;

  logic [MEAN_W-1:0]    mean_q, x_q;
  logic [DIV_BITS-1:0]  quot_q;
  logic [MEAN_W-1:0]    rem_q, divisor_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [STEP_W-1:0]    step_q;

  logic                 out_valid_q, tx_q, va_q;
  logic [FLUSH_W-1:0]   flush_q;
  logic [MEAN_W-1:0]    rms_q;

  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [ENERGY_W:0]            energy_sum;
  logic [MEAN_W:0]              rem_shift;
  logic [MEAN_W:0]              rem_diff;
  logic                         rem_ge;
  logic [MEAN_W:0]              newton_sum;
  logic [MEAN_W-1:0]            mean_sat;
  logic                         skip_rms;
  logic                         send;
  logic [FLUSH_W-1:0]           flush_d;
  logic [LBX_W-1:0]             look_x;
  logic                         voice_dec, was_dec;
  logic [LB_W-1:0]              look_dec;

  assign sq_full    = sample_q * sample_q;
  assign energy_sum = {1'b0, energy_q} + {{(ENERGY_W + 1 - SQUARE_W){1'b0}}, sq_q};
  assign rem_shift  = {rem_q, quot_q[DIV_BITS-1]};
  assign rem_diff   = rem_shift - {1'b0, divisor_q};
  assign rem_ge     = rem_shift >= {1'b0, divisor_q};
  assign newton_sum = {1'b0, x_q} + {1'b0, quot_q[MEAN_W-1:0]};
  assign mean_sat   = (quot_q > {{(DIV_BITS - MEAN_W){1'b0}}, MEAN_MAX}) ? MEAN_MAX
                                                                         : quot_q[MEAN_W-1:0];
  assign skip_rms   = ptt_q || (thr_q == '0);

  assign sts_o.last       = last_q;
  assign sts_o.skip_rms   = skip_rms;
  assign sts_o.div_last   = cnt_q == DIV_CNT_W'(1);
  assign sts_o.mean_zero  = quot_q == '0;
  assign sts_o.steps_last = step_q == STEP_W'(SQRT_STEPS - 1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    send      = 1'b0;
    flush_d   = '0;
    hang_d    = hang_q;
    voice_dec = voice_q;
    was_dec   = was_q;
    look_dec  = look_q;
    if (ptt_q) begin
      send = 1'b1;
    end else if (thr_q != '0) begin
      if (x_q >= {{(MEAN_W - THRESH_W){1'b0}}, thr_q}) begin
        hang_d    = hang_frames_q;
        voice_dec = 1'b1;
      end else if (hang_q != '0) begin
        hang_d = hang_q - HANG_W'(1);
      end else begin
        voice_dec = 1'b0;
      end
      if (voice_dec) begin
        send = 1'b1;
      end else begin
        if (look_q < LB_W'(LOOKBACK_DEPTH)) look_dec = look_q + LB_W'(1);
        was_dec = 1'b0;
      end
    end
    look_x = LBX_W'(look_dec);
    if (send) begin
      if (!was_dec && (look_dec != '0)) begin
        flush_d  = (look_x > LBX_W'(3)) ? FLUSH_W'(3) : look_x[FLUSH_W-1:0];
        look_dec = '0;
      end
      was_dec = 1'b1;
    end

    voice_d  = voice_q;
    was_d    = was_q;
    look_d   = look_q;
    energy_d = energy_q;
    if (cmd_i.decide) begin
      voice_d  = voice_dec;
      was_d    = was_dec;
      look_d   = look_dec;
      energy_d = '0;
    end else begin
      hang_d = hang_q;
    end
    if (cmd_i.accum) begin
      energy_d = energy_sum[ENERGY_W] ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];
    end
    if (cmd_i.load && prev_ptt_q && !ptt_i) begin
      hang_d  = '0;
      voice_d = 1'b0;
    end
    if (cfg_we_i && (cfg_idx_i == CFG_VOX_THRESHOLD)) begin
      hang_d  = '0;
      voice_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q         <= THRESH_RESET;
      hang_frames_q <= HANG_RESET;
      frame_q       <= FRAME_RESET;
      energy_q      <= '0;
      hang_q        <= '0;
      voice_q       <= 1'b0;
      was_q         <= 1'b0;
      look_q        <= '0;
      prev_ptt_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_VOX_THRESHOLD: thr_q         <= cfg_data_i[THRESH_W-1:0];
          CFG_HANG_FRAMES:   hang_frames_q <= cfg_data_i[HANG_W-1:0];
          CFG_FRAME_SAMPLES: frame_q       <= cfg_data_i[FRAME_W-1:0];
          default: ;
        endcase
      end
      energy_q <= energy_d;
      hang_q   <= hang_d;
      voice_q  <= voice_d;
      was_q    <= was_d;
      look_q   <= look_d;
      if (cmd_i.load) prev_ptt_q <= ptt_i;
      if (cmd_i.decide) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
      last_q   <= last_i;
      ptt_q    <= ptt_i;
    end
    if (cmd_i.square) sq_q <= sq_full[SQUARE_W-1:0];
    if (cmd_i.div_start_mean) begin
      quot_q    <= energy_q;
      divisor_q <= (frame_q == '0) ? MEAN_W'(1) : MEAN_W'(frame_q);
      rem_q     <= '0;
      cnt_q     <= DIV_CNT_W'(DIV_BITS);
    end else if (cmd_i.div_start_newton) begin
      quot_q    <= DIV_BITS'(mean_q);
      divisor_q <= x_q;
      rem_q     <= '0;
      cnt_q     <= DIV_CNT_W'(DIV_BITS);
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? rem_diff[MEAN_W-1:0] : rem_shift[MEAN_W-1:0];
      quot_q <= {quot_q[DIV_BITS-2:0], rem_ge};
      cnt_q  <= cnt_q - DIV_CNT_W'(1);
    end
    if (cmd_i.mean_load) begin
      mean_q <= mean_sat;
      x_q    <= mean_sat;
      step_q <= '0;
    end else if (cmd_i.newton_upd) begin
      x_q    <= newton_sum[MEAN_W:1];
      step_q <= step_q + STEP_W'(1);
    end
    if (cmd_i.decide) begin
      tx_q    <= send;
      flush_q <= flush_d;
      va_q    <= voice_dec;
      rms_q   <= skip_rms ? '0 : x_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign transmit_frame_o = tx_q;
  assign flush_count_o    = flush_q;
  assign voice_active_o   = va_q;
  assign frame_rms_o      = rms_q;

endmodule

@@ design/vox_gate_rms_hangtime.sv @@
// Channel   Dir  Payload                                              Handshake
// in_chan   in   sample, last_in_frame, ptt                           valid/ready
// out_chan  out  transmit_frame, flush_count, voice_active, frame_rms valid/ready
// cfg       in   cfg_idx_i, cfg_data_i                                cfg_we_i
//
// Ordinary sample: accept, square and accumulate, in that order.
// Frame end with ptt low and non-zero threshold: mean, then Newton steps if the mean is non-zero,
// on the one-bit-per-cycle divider shared by the mean and every Newton step.
// Frame end with ptt held or zero threshold: straight from accumulate to the decision.
// Reset is asynchronous and needs no clearing pass.
// A result waits in the output register; the next frame end stalls only while it is held.
module vox_gate_rms_hangtime #(
  parameter int LOOKBACK_DEPTH = 3,
  parameter int SQRT_STEPS     = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  vgr_in_if.sink                         in_chan,
  vgr_out_if.source                      out_chan,
  input  logic                           cfg_we_i,
  input  logic [vgr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vgr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import vgr_pkg::*;

  vgr_cmd_t cmd;
  vgr_sts_t sts;

  vgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_chan.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vgr_datapath #(
    .LOOKBACK_DEPTH (LOOKBACK_DEPTH),
    .SQRT_STEPS     (SQRT_STEPS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .sample_i         (in_chan.sample),
    .last_i           (in_chan.last_in_frame),
    .ptt_i            (in_chan.ptt),
    .out_ready_i      (out_chan.ready),
    .out_valid_o      (out_chan.valid),
    .transmit_frame_o (out_chan.transmit_frame),
    .flush_count_o    (out_chan.flush_count),
    .voice_active_o   (out_chan.voice_active),
    .frame_rms_o      (out_chan.frame_rms),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule
